// File: hw/rtl/lrd_pkg.sv
package lrd_pkg;

  // Record framing
  localparam logic [3:0]  HEADER_BYTES    = 4'd13;
  localparam logic [3:0]  MAGIC_BYTES     = 4'd4;
  localparam logic [3:0]  TYPE_INDEX      = 4'd4;
  localparam logic [3:0]  KEY_LEN_END     = 4'd9;
  localparam logic [3:0]  CRC_BYTES       = 4'd4;
  localparam logic [25:0] RECORD_OVERHEAD = 26'd17;
  localparam logic [31:0] CRC_POLY        = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT        = 32'hFFFFFFFF;
  localparam logic [23:0] MAX_PAYLOAD_RST = 24'd65536;

  // Parse phases
  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_KEY    = 2'd1;
  localparam logic [1:0] PH_VALUE  = 2'd2;
  localparam logic [1:0] PH_CRC    = 2'd3;

  // Result kinds
  localparam logic [2:0] OK_KEY    = 3'd0;
  localparam logic [2:0] OK_VALUE  = 3'd1;
  localparam logic [2:0] OK_COMMIT = 3'd2;
  localparam logic [2:0] OK_CLEAN  = 3'd3;
  localparam logic [2:0] OK_TORN   = 3'd4;

  // Input kinds
  localparam logic IN_BYTE = 1'b0;
  localparam logic IN_END  = 1'b1;

  // Register indexes (paddr[2])
  localparam logic REG_MAGIC       = 1'b0;
  localparam logic REG_MAX_PAYLOAD = 1'b1;

  typedef struct packed {
    logic [31:0] magic_word;
    logic [23:0] max_payload_bytes;
  } cfg_t;

  // Reflected CRC-32, one byte
  function automatic logic [31:0] crc32_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] v;
    v = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      v = (v >> 1) ^ (v[0] ? CRC_POLY : 32'd0);
    end
    return v;
  endfunction

endpackage

// File: hw/rtl/log_record_deframer_crc32.sv
// Write-ahead log record parser. Takes one log byte (or an end-of-input mark)
// per cycle and gives at most one result per item, in the next cycle, from a
// result register: each key and value byte as it arrives, a commit with the
// record's type and lengths after a good CRC-32, or a clean/torn end that
// carries the record start offset as the repair point. An item is taken every
// cycle while the result register is empty or being drained; throughput is
// one byte per clock, set by the per-byte CRC-32 update and the header checks
// that share that cycle. After any end the block drops all input until reset.
// Set magic_word and max_payload_bytes over the register port before parsing.
module log_record_deframer_crc32
  import lrd_pkg::*;
#(
  parameter int OFFSET_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // log byte input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [7:0]  in_data_byte,
  // results
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_byte,
  output logic [7:0]  out_record_type,
  output logic [23:0] out_key_length,
  output logic [23:0] out_value_length,
  output logic [31:0] out_record_offset
);

  localparam int SUM_W = ((OFFSET_BITS > 26) ? OFFSET_BITS : 26) + 1;

  cfg_t cfg;

  lrd_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Parser state
  logic [1:0]             phase_r, phase_nxt;
  logic                   finished_r, finished_nxt;
  logic [3:0]             hdr_cnt_r, hdr_cnt_nxt;
  logic [23:0]            field_cnt_r, field_cnt_nxt;
  logic [31:0]            magic_r, magic_nxt;
  logic [7:0]             type_r, type_nxt;
  logic [31:0]            key_len_r, key_len_nxt;
  logic [31:0]            val_len_r, val_len_nxt;
  logic [31:0]            crc_r, crc_nxt;
  logic [31:0]            stored_crc_r, stored_crc_nxt;
  logic [OFFSET_BITS-1:0] start_off_r, start_off_nxt;
  logic [25:0]            total_r, total_nxt;

  // Result register
  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  res_kind_r, res_kind_nxt;
  logic [7:0]  res_byte_r, res_byte_nxt;
  logic [7:0]  res_type_r, res_type_nxt;
  logic [23:0] res_kl_r, res_kl_nxt;
  logic [23:0] res_vl_r, res_vl_nxt;
  logic [31:0] res_off_r, res_off_nxt;

  logic                    accept;
  logic                    emit;
  logic [32:0]             kv_sum;
  logic                    hdr_bad;
  logic [31:0]             crc_upd;
  logic [23:0]             field_inc;
  logic [23:0]             field_len;
  logic [SUM_W-1:0]        off_sum;
  logic [OFFSET_BITS+31:0] off_ext;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign crc_upd   = crc32_byte(crc_r, in_data_byte);
  assign kv_sum    = {1'b0, key_len_r} + {1'b0, val_len_nxt};
  assign hdr_bad   = (magic_r != cfg.magic_word) ||
                     (key_len_r > {8'd0, cfg.max_payload_bytes}) ||
                     (val_len_nxt > {8'd0, cfg.max_payload_bytes}) ||
                     (kv_sum > {9'd0, cfg.max_payload_bytes});
  assign field_inc = field_cnt_r + 24'd1;
  assign field_len = (phase_r == PH_KEY) ? key_len_r[23:0] : val_len_r[23:0];
  assign off_sum   = SUM_W'(start_off_r) + SUM_W'(total_r);
  assign off_ext   = {32'd0, start_off_r};

  // Per-item parse step
  always_comb begin
    phase_nxt      = phase_r;
    finished_nxt   = finished_r;
    hdr_cnt_nxt    = hdr_cnt_r;
    field_cnt_nxt  = field_cnt_r;
    magic_nxt      = magic_r;
    type_nxt       = type_r;
    key_len_nxt    = key_len_r;
    val_len_nxt    = val_len_r;
    crc_nxt        = crc_r;
    stored_crc_nxt = stored_crc_r;
    start_off_nxt  = start_off_r;
    total_nxt      = total_r;
    emit           = 1'b0;
    res_kind_nxt   = OK_TORN;
    res_byte_nxt   = 8'd0;
    res_type_nxt   = 8'd0;
    res_kl_nxt     = 24'd0;
    res_vl_nxt     = 24'd0;

    // header fields shift in before the checks see them
    if (phase_r == PH_HEADER) begin
      if (hdr_cnt_r >= TYPE_INDEX + 4'd1 && hdr_cnt_r < KEY_LEN_END) begin
        key_len_nxt = {key_len_r[23:0], in_data_byte};
      end
      if (hdr_cnt_r >= KEY_LEN_END) begin
        val_len_nxt = {val_len_r[23:0], in_data_byte};
      end
    end

    if (accept && !finished_r) begin
      if (in_kind == IN_END) begin
        emit         = 1'b1;
        finished_nxt = 1'b1;
        res_kind_nxt = (phase_r == PH_HEADER && hdr_cnt_r == 4'd0) ? OK_CLEAN : OK_TORN;
      end else begin
        case (phase_r)
          PH_HEADER: begin
            if (hdr_cnt_r < MAGIC_BYTES) begin
              magic_nxt = {magic_r[23:0], in_data_byte};
            end else begin
              crc_nxt = crc_upd;
            end
            if (hdr_cnt_r == TYPE_INDEX) begin
              type_nxt = in_data_byte;
            end
            hdr_cnt_nxt = hdr_cnt_r + 4'd1;
            if (hdr_cnt_r == HEADER_BYTES - 4'd1) begin
              if (hdr_bad) begin
                emit         = 1'b1;
                finished_nxt = 1'b1;
                res_kind_nxt = OK_TORN;
              end else begin
                total_nxt     = kv_sum[25:0] + RECORD_OVERHEAD;
                field_cnt_nxt = 24'd0;
                hdr_cnt_nxt   = 4'd0;
                if (key_len_r != 32'd0) begin
                  phase_nxt = PH_KEY;
                end else if (val_len_nxt != 32'd0) begin
                  phase_nxt = PH_VALUE;
                end else begin
                  phase_nxt = PH_CRC;
                end
              end
            end
          end
          PH_KEY, PH_VALUE: begin
            crc_nxt       = crc_upd;
            emit          = 1'b1;
            res_kind_nxt  = (phase_r == PH_KEY) ? OK_KEY : OK_VALUE;
            res_byte_nxt  = in_data_byte;
            field_cnt_nxt = field_inc;
            // advance to the next non-empty field
            if (field_inc >= field_len) begin
              field_cnt_nxt = 24'd0;
              hdr_cnt_nxt   = 4'd0;
              if (phase_r == PH_KEY && val_len_r != 32'd0) begin
                phase_nxt = PH_VALUE;
              end else begin
                phase_nxt = PH_CRC;
              end
            end
          end
          PH_CRC: begin
            stored_crc_nxt = {stored_crc_r[23:0], in_data_byte};
            hdr_cnt_nxt    = hdr_cnt_r + 4'd1;
            if (hdr_cnt_r == CRC_BYTES - 4'd1) begin
              emit = 1'b1;
              if (stored_crc_nxt != ~crc_r) begin
                finished_nxt = 1'b1;
                res_kind_nxt = OK_TORN;
              end else begin
                res_kind_nxt = OK_COMMIT;
                res_type_nxt = type_r;
                res_kl_nxt   = key_len_r[23:0];
                res_vl_nxt   = val_len_r[23:0];
                // advance record start, saturating
                if (off_sum[SUM_W-1:OFFSET_BITS] != '0) begin
                  start_off_nxt = '1;
                end else begin
                  start_off_nxt = off_sum[OFFSET_BITS-1:0];
                end
                phase_nxt      = PH_HEADER;
                field_cnt_nxt  = 24'd0;
                hdr_cnt_nxt    = 4'd0;
                magic_nxt      = 32'd0;
                type_nxt       = 8'd0;
                key_len_nxt    = 32'd0;
                val_len_nxt    = 32'd0;
                crc_nxt        = CRC_INIT;
                stored_crc_nxt = 32'd0;
              end
            end
          end
          default: ;
        endcase
      end
    end else begin
      // hold length shifters when no byte is taken
      key_len_nxt = key_len_r;
      val_len_nxt = val_len_r;
    end

    res_off_nxt = off_ext[31:0];
  end

  // Hold a stalled result, else load the new one
  always_comb begin
    if (out_valid_r && out_stall) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = accept && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HEADER;
      finished_r   <= 1'b0;
      hdr_cnt_r    <= 4'd0;
      field_cnt_r  <= 24'd0;
      magic_r      <= 32'd0;
      type_r       <= 8'd0;
      key_len_r    <= 32'd0;
      val_len_r    <= 32'd0;
      crc_r        <= CRC_INIT;
      stored_crc_r <= 32'd0;
      start_off_r  <= '0;
      total_r      <= 26'd0;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      finished_r   <= finished_nxt;
      hdr_cnt_r    <= hdr_cnt_nxt;
      field_cnt_r  <= field_cnt_nxt;
      magic_r      <= magic_nxt;
      type_r       <= type_nxt;
      key_len_r    <= key_len_nxt;
      val_len_r    <= val_len_nxt;
      crc_r        <= crc_nxt;
      stored_crc_r <= stored_crc_nxt;
      start_off_r  <= start_off_nxt;
      total_r      <= total_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Result payload, loaded only with a new transaction
  always_ff @(posedge clk) begin
    if (accept && emit) begin
      res_kind_r <= res_kind_nxt;
      res_byte_r <= res_byte_nxt;
      res_type_r <= res_type_nxt;
      res_kl_r   <= res_kl_nxt;
      res_vl_r   <= res_vl_nxt;
      res_off_r  <= res_off_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = res_kind_r;
  assign out_byte          = res_byte_r;
  assign out_record_type   = res_type_r;
  assign out_key_length    = res_kl_r;
  assign out_value_length  = res_vl_r;
  assign out_record_offset = res_off_r;

endmodule

// File: hw/rtl/lrd_cfg_regs.sv
module lrd_cfg_regs
  import lrd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic [31:0] magic_word_r;
  logic [23:0] max_payload_r;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Write registers on the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_word_r  <= 32'd0;
      max_payload_r <= MAX_PAYLOAD_RST;
    end else if (wr_en) begin
      case (paddr[2])
        REG_MAGIC:       magic_word_r  <= pwdata;
        REG_MAX_PAYLOAD: max_payload_r <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (paddr[2])
      REG_MAGIC:       prdata = magic_word_r;
      REG_MAX_PAYLOAD: prdata = {8'd0, max_payload_r};
      default:         prdata = 32'd0;
    endcase
  end

  assign cfg.magic_word        = magic_word_r;
  assign cfg.max_payload_bytes = max_payload_r;

endmodule

// File: bench/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lrd_pkg::*;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data;
    logic [7:0]  rtype;
    logic [23:0] klen;
    logic [23:0] vlen;
    logic [31:0] offset;
  } log_result_t;

  typedef enum int {
    END_CLEAN, END_MID_RECORD, BAD_MAGIC, KEY_TOO_LONG, VALUE_TOO_LONG, SUM_TOO_LONG, BAD_CRC
  } stream_end_t;

  // Tracks the parser state and the queue of results it still owes
  class log_scoreboard;
    logic [31:0] magic_cfg;
    logic [23:0] limit_cfg;
    logic [1:0]  phase;
    logic [23:0] field_cnt;
    logic [3:0]  hdr_cnt;
    logic [31:0] magic_acc;
    logic [31:0] klen;
    logic [31:0] vlen;
    logic [31:0] crc;
    logic [31:0] stored_crc;
    logic [31:0] start_off;
    logic [7:0]  rtype;
    bit          ended;
    log_result_t pending_results[$];
    int unsigned errors;
    int unsigned results_seen;

    function new();
      magic_cfg = '0;
      limit_cfg = MAX_PAYLOAD_RST;
      start_off = '0;
      ended = 1'b0;
      errors = 0;
      results_seen = 0;
      clear_record();
    endfunction

    static function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'd0, b};
      repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      return r;
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 100) $display("mismatch: %s", msg);
    endfunction

    function int unsigned pending_count();
      return pending_results.size();
    endfunction

    function void set_register(logic idx, logic [31:0] value);
      if (idx == REG_MAGIC) magic_cfg = value;
      else limit_cfg = value[23:0];
    endfunction

    function void clear_record();
      phase = PH_HEADER;
      field_cnt = '0;
      hdr_cnt = '0;
      magic_acc = '0;
      rtype = '0;
      klen = '0;
      vlen = '0;
      crc = '1;
      stored_crc = '0;
    endfunction

    function void expect_result(logic [2:0] kind, logic [7:0] data, logic [7:0] ty,
                                logic [23:0] kl, logic [23:0] vl);
      pending_results.push_back(log_result_t'{kind, data, ty, kl, vl, start_off});
    endfunction

    function void end_stream(logic [2:0] kind);
      expect_result(kind, '0, '0, '0, '0);
      ended = 1'b1;
    endfunction

    // Skip empty key or value fields
    function void next_field();
      field_cnt = '0;
      if (phase == PH_HEADER && klen != 0) phase = PH_KEY;
      else if ((phase == PH_HEADER || phase == PH_KEY) && vlen != 0) phase = PH_VALUE;
      else phase = PH_CRC;
      hdr_cnt = '0;
    endfunction

    // Move the record start past a committed record, saturating at the top
    function void advance_offset();
      logic [33:0] total;
      total = {8'd0, RECORD_OVERHEAD} + {2'd0, klen} + {2'd0, vlen};
      if (total > {2'd0, ~start_off}) start_off = '1;
      else start_off = start_off + total[31:0];
    endfunction

    // Predict the result of one accepted input transaction
    function void take_item(logic kind, logic [7:0] b);
      if (ended) return;
      if (kind == IN_END) begin
        end_stream((phase == PH_HEADER && hdr_cnt == 0) ? OK_CLEAN : OK_TORN);
        return;
      end
      case (phase)
        PH_HEADER: begin
          if (hdr_cnt < MAGIC_BYTES) magic_acc = {magic_acc[23:0], b};
          else crc = crc_step(crc, b);
          if (hdr_cnt == TYPE_INDEX) rtype = b;
          else if (hdr_cnt > TYPE_INDEX && hdr_cnt < KEY_LEN_END) klen = {klen[23:0], b};
          else if (hdr_cnt >= KEY_LEN_END) vlen = {vlen[23:0], b};
          hdr_cnt++;
          if (hdr_cnt == HEADER_BYTES) begin
            if (magic_acc != magic_cfg || klen > limit_cfg || vlen > limit_cfg ||
                {1'b0, klen} + {1'b0, vlen} > {9'd0, limit_cfg})
              end_stream(OK_TORN);
            else
              next_field();
          end
        end
        PH_KEY, PH_VALUE: begin
          crc = crc_step(crc, b);
          expect_result((phase == PH_KEY) ? OK_KEY : OK_VALUE, b, '0, '0, '0);
          field_cnt++;
          if (field_cnt >= ((phase == PH_KEY) ? klen[23:0] : vlen[23:0])) next_field();
        end
        default: begin
          stored_crc = {stored_crc[23:0], b};
          hdr_cnt++;
          if (hdr_cnt == CRC_BYTES) begin
            if (stored_crc != ~crc) begin
              end_stream(OK_TORN);
            end else begin
              expect_result(OK_COMMIT, '0, rtype, klen[23:0], vlen[23:0]);
              advance_offset();
              clear_record();
            end
          end
        end
      endcase
    endfunction

    // Compare one result transaction with the oldest expectation
    function void check_result(log_result_t got);
      log_result_t want;
      results_seen++;
      if (pending_results.size() == 0) begin
        report($sformatf("result %0d unexpected, kind %0d", results_seen, got.kind));
        return;
      end
      want = pending_results.pop_front();
      if (got.kind !== want.kind)
        report($sformatf("result %0d kind %0d, want %0d", results_seen, got.kind, want.kind));
      if (got.data !== want.data)
        report($sformatf("result %0d byte %h, want %h", results_seen, got.data, want.data));
      if (got.rtype !== want.rtype)
        report($sformatf("result %0d type %h, want %h", results_seen, got.rtype, want.rtype));
      if (got.klen !== want.klen)
        report($sformatf("result %0d key length %0d, want %0d", results_seen, got.klen,
                         want.klen));
      if (got.vlen !== want.vlen)
        report($sformatf("result %0d value length %0d, want %0d", results_seen, got.vlen,
                         want.vlen));
      if (got.offset !== want.offset)
        report($sformatf("result %0d offset %0d, want %0d", results_seen, got.offset,
                         want.offset));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_stall;
  logic        in_kind;
  logic [7:0]  in_data_byte;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_kind;
  logic [7:0]  out_byte;
  logic [7:0]  out_record_type;
  logic [23:0] out_key_length;
  logic [23:0] out_value_length;
  logic [31:0] out_record_offset;

  log_scoreboard sb;
  logic [7:0]    frame_bytes[$];
  logic [31:0]   magic_now;
  logic [23:0]   limit_now;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  int unsigned   bytes_sent = 0;

  log_record_deframer_crc32 dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_byte          (out_byte),
    .out_record_type   (out_record_type),
    .out_key_length    (out_key_length),
    .out_value_length  (out_value_length),
    .out_record_offset (out_record_offset)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Throttle the result channel
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Check every accepted result transaction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(log_result_t'{out_kind, out_byte, out_record_type, out_key_length,
                                    out_value_length, out_record_offset});
  end

  // Drive one input transaction and hold it until accepted
  task automatic send_item(input logic kind, input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_item(kind, b);
    bytes_sent++;
  endtask

  // Hold off input until every expected result has arrived, then settle
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_count() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write a register, then read it back
  task automatic write_reg(input logic idx, input logic [31:0] value);
    logic [31:0] want;
    want = (idx == REG_MAGIC) ? value : {8'd0, value[23:0]};
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_register(idx, value);
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want)
      sb.report($sformatf("register %0d reads %h, want %h", idx, prdata, want));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_framing(input logic [31:0] magic, input logic [23:0] limit);
    write_reg(REG_MAGIC, magic);
    write_reg(REG_MAX_PAYLOAD, {8'd0, limit});
    magic_now = magic;
    limit_now = limit;
  endtask

  // Assemble a record: header, then with_body random key and value bytes and a CRC
  function automatic void build_record(input logic [31:0] magic, input logic [7:0] rtype,
                                       input logic [31:0] klen, input logic [31:0] vlen,
                                       input bit with_body, input bit bad_crc);
    logic [31:0] crc;
    logic [7:0]  b;
    frame_bytes.delete();
    for (int i = 3; i >= 0; i--) frame_bytes.push_back(magic[8*i +: 8]);
    frame_bytes.push_back(rtype);
    for (int i = 3; i >= 0; i--) frame_bytes.push_back(klen[8*i +: 8]);
    for (int i = 3; i >= 0; i--) frame_bytes.push_back(vlen[8*i +: 8]);
    crc = CRC_INIT;
    for (int i = 4; i < 13; i++) crc = log_scoreboard::crc_step(crc, frame_bytes[i]);
    if (!with_body) return;
    for (int unsigned i = 0; i < klen + vlen; i++) begin
      b = 8'($urandom);
      frame_bytes.push_back(b);
      crc = log_scoreboard::crc_step(crc, b);
    end
    crc = ~crc;
    if (bad_crc) crc = crc ^ (32'd1 << $urandom_range(31));
    for (int i = 3; i >= 0; i--) frame_bytes.push_back(crc[8*i +: 8]);
  endfunction

  // Send the first count bytes of the frame, draining once before pause_at
  task automatic send_frame(input int count, input int pause_at);
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) wait_drained();
      send_item(IN_BYTE, frame_bytes[i]);
    end
  endtask

  task automatic send_record(input logic [7:0] rtype, input int unsigned klen,
                             input int unsigned vlen, input int pause_at);
    build_record(magic_now, rtype, klen, vlen, 1'b1, 1'b0);
    send_frame(frame_bytes.size(), pause_at);
  endtask

  // Mostly short fields, now and then a longer one
  function automatic int unsigned rand_len(input int unsigned cap);
    int unsigned hi;
    hi = ($urandom_range(9) < 7) ? 6 : 40;
    if (hi > cap) hi = cap;
    return $urandom_range(hi);
  endfunction

  task automatic send_random_records(input int unsigned until_bytes);
    int unsigned k;
    while (bytes_sent < until_bytes) begin
      k = rand_len(limit_now);
      send_record(8'($urandom), k, rand_len(limit_now - k), -1);
    end
  endtask

  // Close the stream one way, then show that later input is dropped
  task automatic finish_stream();
    stream_end_t how;
    int unsigned k;
    int unsigned v;
    logic [31:0] over;
    how = stream_end_t'($urandom_range(int'(BAD_CRC)));
    k = rand_len(limit_now);
    v = rand_len(limit_now - k);
    over = $urandom_range(1) ? {8'd0, limit_now} + 32'd1 : ($urandom | 32'h8000_0000);
    case (how)
      END_CLEAN: ;
      END_MID_RECORD: begin
        build_record(magic_now, 8'($urandom), k, v, 1'b1, 1'b0);
        send_frame($urandom_range(frame_bytes.size() - 1, 1), -1);
      end
      BAD_MAGIC: begin
        build_record(magic_now ^ (32'd1 << $urandom_range(31)), 8'($urandom), k, v, 1'b1,
                     1'b0);
        send_frame(frame_bytes.size(), -1);
      end
      KEY_TOO_LONG: begin
        build_record(magic_now, 8'($urandom), over, v, 1'b0, 1'b0);
        send_frame(frame_bytes.size(), -1);
      end
      VALUE_TOO_LONG: begin
        build_record(magic_now, 8'($urandom), k, over, 1'b0, 1'b0);
        send_frame(frame_bytes.size(), -1);
      end
      SUM_TOO_LONG: begin
        k = $urandom_range(limit_now, 1);
        v = $urandom_range(limit_now, limit_now - k + 1);
        build_record(magic_now, 8'($urandom), k, v, 1'b0, 1'b0);
        send_frame(frame_bytes.size(), -1);
      end
      default: begin
        build_record(magic_now, 8'($urandom), k, v, 1'b1, 1'b1);
        send_frame(frame_bytes.size(), -1);
      end
    endcase
    send_item(IN_END, 8'($urandom));
    repeat (12) send_item(1'($urandom_range(1)), 8'($urandom));
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    in_kind = IN_BYTE;
    in_data_byte = '0;
    out_stall = 1'b0;
    magic_now = '0;
    limit_now = MAX_PAYLOAD_RST;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Sender light, receiver heavy; widest payload limit
    send_idle_pct = 35;
    recv_idle_pct = 71;
    set_framing(32'h0000_0000, 24'hFF_FFFF);
    send_record(8'h00, 0, 0, -1);
    send_record(8'hFF, 1, 0, -1);
    send_record(8'h5A, 0, 1, -1);
    build_record(magic_now, 8'hA5, 2, 2, 1'b1, 1'b0);
    frame_bytes[13] = 8'h00;
    frame_bytes[14] = 8'hFF;
    frame_bytes[15] = 8'hFF;
    frame_bytes[16] = 8'h00;
    build_record(magic_now, 8'hA5, 2, 2, 1'b0, 1'b0);
    send_record(8'hA5, 2, 2, -1);
    send_random_records(420);

    // Swap the idling; tight limit, records right at it
    wait_drained();
    send_idle_pct = 71;
    recv_idle_pct = 35;
    set_framing(32'hFFFF_FFFF, 24'd12);
    send_record(8'($urandom), 12, 0, -1);
    send_record(8'($urandom), 0, 12, -1);
    send_record(8'($urandom), 5, 7, 15);
    send_random_records(840);

    // No idling; zero limit allows only empty records, then limit 40 and a stream end
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_framing($urandom, 24'd0);
    send_record(8'($urandom), 0, 0, -1);
    send_record(8'($urandom), 0, 0, -1);
    wait_drained();
    set_framing($urandom, 24'd40);
    send_random_records(1250);
    finish_stream();

    wait_drained();
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Give up on a hung run
  initial begin
    #(3_000_000);
    $display("status: fail");
    $finish;
  end

endmodule
